// ===== design/rslc_pkg.sv =====
`timescale 1ns / 1ps

package rslc_pkg;

    localparam int FREQ_W = 30;
    localparam int RSSI_W = 10;
    localparam int LIST_IDX_W = 6;
    localparam int RANGE_IDX_W = 3;
    localparam int LEVEL_W = 3;
    localparam int LED_W = 3;
    localparam int BEEP_W = 9;
    localparam int CLAMP_W = 8;

    localparam int LIST_TABLE_SIZE = 15;
    localparam int RANGE_TABLE_SIZE = 3;

    localparam logic [FREQ_W-1:0] STEP_HZ = 30'd250000;
    localparam logic [FREQ_W-1:0] BAND_LOW = 30'd924000000;
    localparam logic [FREQ_W-1:0] BAND_HIGH = 30'd928000000;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 30'd300000000;

    localparam logic signed [RSSI_W-1:0] BAND_THRESHOLD = -10'sd90;
    localparam logic signed [RSSI_W-1:0] THRESHOLD_RESET = -10'sd130;
    localparam logic signed [RSSI_W:0] CONFIRM_MARGIN = 11'sd10;
    localparam logic signed [RSSI_W:0] RSSI_OFFSET = 11'sd220;
    localparam logic signed [RSSI_W:0] CLAMP_TOP = 11'sd180;

    localparam logic [BEEP_W-1:0] BEEP_BASE = 9'd500;
    localparam logic [BEEP_W-1:0] BEEP_FLOOR = 9'd20;

    typedef enum logic [1:0] {
        OP_ADVANCE = 2'd0,
        OP_MEASURE = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    localparam logic [LED_W-1:0] LED_NONE = 3'd0;
    localparam logic [LED_W-1:0] LED_BLUE_OFF = 3'd1;
    localparam logic [LED_W-1:0] LED_BLUE_ON = 3'd2;
    localparam logic [LED_W-1:0] LED_GREEN = 3'd3;
    localparam logic [LED_W-1:0] LED_YELLOW = 3'd4;
    localparam logic [LED_W-1:0] LED_RED = 3'd5;

    typedef struct packed {
        logic advance;
        logic release_lock;
    } scan_cmd_t;

    // Common frequency list; indexes past the table wrap around its size.
    function automatic logic [FREQ_W-1:0] list_freq(input logic [LIST_IDX_W-1:0] idx);
        logic [LIST_IDX_W-1:0] m;
        logic [FREQ_W-1:0] f;
        m = idx;
        for (int i = 0; i < 4; i++)
        begin
            if (m >= LIST_IDX_W'(LIST_TABLE_SIZE))
                m = m - LIST_IDX_W'(LIST_TABLE_SIZE);
        end
        case (m)
            6'd0: f = 30'd315000000;
            6'd1: f = 30'd318000000;
            6'd2: f = 30'd390000000;
            6'd3: f = 30'd433075000;
            6'd4: f = 30'd433420000;
            6'd5: f = 30'd433889000;
            6'd6: f = 30'd433920000;
            6'd7: f = 30'd434420000;
            6'd8: f = 30'd434775000;
            6'd9: f = 30'd438900000;
            6'd10: f = 30'd868350000;
            6'd11: f = 30'd868850000;
            6'd12: f = 30'd868950000;
            6'd13: f = 30'd915000000;
            6'd14: f = 30'd925000000;
            default: f = 30'd315000000;
        endcase
        return f;
    endfunction

    function automatic logic [1:0] range_wrap(input logic [RANGE_IDX_W-1:0] idx);
        logic [RANGE_IDX_W-1:0] m;
        m = idx;
        for (int i = 0; i < 2; i++)
        begin
            if (m >= RANGE_IDX_W'(RANGE_TABLE_SIZE))
                m = m - RANGE_IDX_W'(RANGE_TABLE_SIZE);
        end
        return m[1:0];
    endfunction

    function automatic logic [FREQ_W-1:0] band_start(input logic [RANGE_IDX_W-1:0] idx);
        logic [FREQ_W-1:0] f;
        case (range_wrap(idx))
            2'd0: f = 30'd300000000;
            2'd1: f = 30'd387000000;
            2'd2: f = 30'd779000000;
            default: f = 30'd300000000;
        endcase
        return f;
    endfunction

    function automatic logic [FREQ_W-1:0] band_end(input logic [RANGE_IDX_W-1:0] idx);
        logic [FREQ_W-1:0] f;
        case (range_wrap(idx))
            2'd0: f = 30'd348000000;
            2'd1: f = 30'd464000000;
            2'd2: f = 30'd928000000;
            default: f = 30'd348000000;
        endcase
        return f;
    endfunction

endpackage

// ===== design/rslc_scan.sv =====
`timescale 1ns / 1ps

module rslc_scan
    import rslc_pkg::*;
#(
    parameter int LIST_LENGTH = 15,
    parameter int RANGE_TOTAL = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  scan_cmd_t         cmd,
    output logic [FREQ_W-1:0] held_frequency,
    output logic [FREQ_W-1:0] held_frequency_next
);

    localparam int LW = (LIST_LENGTH > 1) ? $clog2(LIST_LENGTH) : 1;
    localparam int RW = (RANGE_TOTAL > 1) ? $clog2(RANGE_TOTAL) : 1;
    localparam logic [LW-1:0] LIST_LAST = LW'(LIST_LENGTH - 1);
    localparam logic [RW-1:0] RANGE_LAST = RW'(RANGE_TOTAL - 1);

    logic [FREQ_W-1:0] sweep_position_reg, sweep_position_next;
    logic [RW-1:0]     range_select_reg, range_select_next;
    logic [LW-1:0]     list_select_reg, list_select_next;
    logic              in_list_pass_reg, in_list_pass_next;
    logic [FREQ_W-1:0] held_frequency_reg;
    logic [FREQ_W-1:0] stepped_position;
    logic [RW-1:0]     range_advanced;

    assign stepped_position = sweep_position_reg + STEP_HZ;
    assign range_advanced = (range_select_reg == RANGE_LAST) ? '0 : range_select_reg + 1'b1;

    always_comb
    begin
        sweep_position_next = sweep_position_reg;
        range_select_next = range_select_reg;
        list_select_next = list_select_reg;
        in_list_pass_next = in_list_pass_reg;
        held_frequency_next = held_frequency_reg;
        if (cmd.advance)
        begin
            if (in_list_pass_reg)
            begin
                held_frequency_next = list_freq(LIST_IDX_W'(list_select_reg));
                if (list_select_reg == LIST_LAST)
                begin
                    list_select_next = '0;
                    in_list_pass_next = 1'b0;
                end
                else
                begin
                    list_select_next = list_select_reg + 1'b1;
                end
            end
            else if (stepped_position > band_end(RANGE_IDX_W'(range_select_reg)))
            begin
                // Past the end of this range: move on and replay the list first.
                range_select_next = range_advanced;
                sweep_position_next = band_start(RANGE_IDX_W'(range_advanced));
                in_list_pass_next = 1'b1;
                held_frequency_next = sweep_position_next;
            end
            else
            begin
                sweep_position_next = stepped_position;
                held_frequency_next = stepped_position;
            end
        end
        else if (cmd.release_lock)
        begin
            in_list_pass_next = 1'b1;
            list_select_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_position_reg <= FREQ_RESET;
            range_select_reg <= '0;
            list_select_reg <= '0;
            in_list_pass_reg <= 1'b1;
            held_frequency_reg <= FREQ_RESET;
        end
        else
        begin
            sweep_position_reg <= sweep_position_next;
            range_select_reg <= range_select_next;
            list_select_reg <= list_select_next;
            in_list_pass_reg <= in_list_pass_next;
            held_frequency_reg <= held_frequency_next;
        end
    end

    assign held_frequency = held_frequency_reg;

endmodule

// ===== design/rslc_meter.sv =====
`timescale 1ns / 1ps

module rslc_meter
    import rslc_pkg::*;
(
    input  logic signed [RSSI_W-1:0] rssi,
    output logic [LEVEL_W-1:0]       level,
    output logic [BEEP_W-1:0]        beep_interval
);

    logic signed [RSSI_W:0] shifted;
    logic [CLAMP_W-1:0]     n;
    logic [BEEP_W+1:0]      n_times5;
    logic [BEEP_W-1:0]      beep_raw;

    assign shifted = $signed({rssi[RSSI_W-1], rssi}) + RSSI_OFFSET;

    always_comb
    begin
        if (shifted < 0)
            n = '0;
        else if (shifted > CLAMP_TOP)
            n = CLAMP_W'(CLAMP_TOP);
        else
            n = CLAMP_W'(shifted);
    end

    // floor(n * 499 / 18000) steps up at n = 37, 73, 109 and 145 over 0..180.
    assign level = LEVEL_W'(1) + LEVEL_W'(n >= 8'd37) + LEVEL_W'(n >= 8'd73)
                 + LEVEL_W'(n >= 8'd109) + LEVEL_W'(n >= 8'd145);

    assign n_times5 = {n, 2'b00} + (BEEP_W+2)'(n);
    assign beep_raw = BEEP_BASE - BEEP_W'(n_times5 >> 1);
    assign beep_interval = (beep_raw < BEEP_FLOOR) ? BEEP_FLOOR : beep_raw;

endmodule

// ===== design/rf_scan_lock_controller.sv =====
`timescale 1ns / 1ps
// A transaction accepted on s_* sits in the input register and is written to the result
// register once that register is empty or its result is being taken; it then shows on m_*.
// Throughput: one transaction per cycle while m_tready is high; the result register frees as taken.
// Reset: rst_n clears the pipeline, the scan state, the lock and the threshold
// register to -130 dBm at once, asynchronously.

module rf_scan_lock_controller
    import rslc_pkg::*;
#(
    parameter int LIST_LENGTH = 15,
    parameter int RANGE_TOTAL = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,   // lock_threshold
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // rssi[9:0], rssi_confirm[19:10], zero pad
    input  logic [1:0]  s_tuser,     // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata      // tune_frequency[29:0], locked[30], level[33:31],
                                     // led_code[36:34], beep_interval_ms[45:37], zero pad
);

    logic                     s1_valid_reg;
    logic [1:0]               s1_op_reg;
    logic signed [RSSI_W-1:0] s1_rssi_reg;
    logic signed [RSSI_W-1:0] s1_confirm_reg;

    logic                     m_valid_reg, m_valid_next;
    logic [47:0]              m_data_reg;

    logic signed [RSSI_W-1:0] threshold_reg;
    logic                     lock_reg, lock_next;
    logic                     blue_reg, blue_next;

    logic                     out_free;
    logic                     step;
    scan_cmd_t                cmd;
    logic [FREQ_W-1:0]        held_frequency;
    logic [FREQ_W-1:0]        held_frequency_next;
    logic [LEVEL_W-1:0]       meter_level;
    logic [BEEP_W-1:0]        meter_beep;
    logic signed [RSSI_W-1:0] thr;
    logic                     over_threshold;
    logic [LEVEL_W-1:0]       level;
    logic [LED_W-1:0]         led_code;
    logic [BEEP_W-1:0]        beep;

    assign out_free = !m_valid_reg || m_tready;
    assign step = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    always_comb
    begin
        cmd.advance = step && (s1_op_reg == OP_ADVANCE) && !lock_reg;
        cmd.release_lock = step && (s1_op_reg == OP_RELEASE);
    end

    rslc_scan #(
        .LIST_LENGTH(LIST_LENGTH),
        .RANGE_TOTAL(RANGE_TOTAL)
    ) u_scan (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .held_frequency      (held_frequency),
        .held_frequency_next (held_frequency_next)
    );

    rslc_meter u_meter (
        .rssi          (s1_rssi_reg),
        .level         (meter_level),
        .beep_interval (meter_beep)
    );

    // Inside the override band the threshold is fixed at -90 dBm.
    assign thr = (held_frequency >= BAND_LOW && held_frequency <= BAND_HIGH)
               ? BAND_THRESHOLD : threshold_reg;
    assign over_threshold = (s1_rssi_reg > thr)
        && ($signed({s1_confirm_reg[RSSI_W-1], s1_confirm_reg})
            > $signed({thr[RSSI_W-1], thr}) - CONFIRM_MARGIN);

    always_comb
    begin
        lock_next = lock_reg;
        blue_next = blue_reg;
        level = LEVEL_W'(1);
        led_code = LED_NONE;
        beep = '0;
        case (s1_op_reg)
            OP_MEASURE:
            begin
                level = meter_level;
                if (!lock_reg && over_threshold)
                    lock_next = 1'b1;
                if (!lock_next)
                begin
                    blue_next = !blue_reg;
                    led_code = blue_next ? LED_BLUE_ON : LED_BLUE_OFF;
                end
                else
                begin
                    if (meter_level == LEVEL_W'(1))
                        led_code = LED_GREEN;
                    else if (meter_level <= LEVEL_W'(3))
                        led_code = LED_YELLOW;
                    else
                        led_code = LED_RED;
                    beep = meter_beep;
                end
            end
            OP_RELEASE:
            begin
                lock_next = 1'b0;
            end
            default:
            begin
                lock_next = lock_reg;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (step)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            threshold_reg <= THRESHOLD_RESET;
            lock_reg <= 1'b0;
            blue_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
                threshold_reg <= cfg_wdata;
            if (step)
            begin
                lock_reg <= lock_next;
                blue_reg <= blue_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_op_reg <= s_tuser;
            s1_rssi_reg <= s_tdata[9:0];
            s1_confirm_reg <= s_tdata[19:10];
        end
        if (step)
            m_data_reg <= {2'b00, beep, led_code, level, lock_next, held_frequency_next};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

endmodule

// ===== design/rslc_checker.sv =====
`timescale 1ns / 1ps

module rslc_checker
    import rslc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // A result that is not taken stays offered unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[33:31] >= 3'd1 && m_tdata[33:31] <= 3'd5)
        else $error("level out of range");

    // The beep interval is zero while unlocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[30] |-> m_tdata[45:37] == 9'd0)
        else $error("beep interval given while unlocked");

    // A locked result with a nonzero beep interval carries a level color, never a blue or idle code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[30] && m_tdata[45:37] != 9'd0
            |-> m_tdata[45:37] >= BEEP_FLOOR
                && (m_tdata[36:34] == LED_GREEN || m_tdata[36:34] == LED_YELLOW
                    || m_tdata[36:34] == LED_RED))
        else $error("locked measurement result inconsistent");

endmodule

bind rf_scan_lock_controller rslc_checker u_rslc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
